// ----- hdl/kbalu_pkg.sv -----
// ----------------------------------------------------------------------------
// kbalu_pkg: shared types and constants for the known-bits abstract ALU
// Holds the word types, operation and predicate codes, the per-bit abstract
// value encoding and the three-valued bitwise tables.
// ----------------------------------------------------------------------------
package kbalu_pkg;

  // Width of every mask field in a word.
  localparam int unsigned DATA_W = 32;

  // Operation codes.
  localparam logic [2:0] OP_AND  = 3'd0;
  localparam logic [2:0] OP_OR   = 3'd1;
  localparam logic [2:0] OP_XOR  = 3'd2;
  localparam logic [2:0] OP_SHL  = 3'd3;
  localparam logic [2:0] OP_LSHR = 3'd4;
  localparam logic [2:0] OP_ASHR = 3'd5;
  localparam logic [2:0] OP_ICMP = 3'd6;

  // Compare predicate codes.
  localparam logic [3:0] PRED_EQ  = 4'd0;
  localparam logic [3:0] PRED_NE  = 4'd1;
  localparam logic [3:0] PRED_UGT = 4'd2;
  localparam logic [3:0] PRED_UGE = 4'd3;
  localparam logic [3:0] PRED_ULT = 4'd4;
  localparam logic [3:0] PRED_ULE = 4'd5;
  localparam logic [3:0] PRED_SGT = 4'd6;
  localparam logic [3:0] PRED_SGE = 4'd7;
  localparam logic [3:0] PRED_SLT = 4'd8;
  localparam logic [3:0] PRED_SLE = 4'd9;

  // One abstract bit, packed as {can_one, can_zero}.
  typedef enum logic [1:0] {
    KB_BOT  = 2'b00,
    KB_ZERO = 2'b01,
    KB_ONE  = 2'b10,
    KB_TOP  = 2'b11
  } kb_t;

  // Input word.
  typedef struct packed {
    logic [2:0]        op;
    logic [3:0]        predicate;
    logic [DATA_W-1:0] a_can_zero;
    logic [DATA_W-1:0] a_can_one;
    logic [DATA_W-1:0] b_can_zero;
    logic [DATA_W-1:0] b_can_one;
  } kbalu_in_t;

  // Result word.
  typedef struct packed {
    logic [DATA_W-1:0] res_can_zero;
    logic [DATA_W-1:0] res_can_one;
  } kbalu_out_t;

  // Build an abstract bit from its two mask bits.
  function automatic kb_t kb_pack(input logic z, input logic o);
    return kb_t'({o, z});
  endfunction

  // True when the bit holds a single concrete value.
  function automatic logic kb_known(input kb_t v);
    return (v == KB_ZERO) || (v == KB_ONE);
  endfunction

  // Three-valued AND: a known zero dominates everything.
  function automatic kb_t tab_and(input kb_t x, input kb_t y);
    kb_t v;
    if ((x == KB_ZERO) || (y == KB_ZERO)) begin
      v = KB_ZERO;
    end else if ((x == KB_TOP) || (y == KB_TOP)) begin
      v = KB_TOP;
    end else if ((x == KB_BOT) || (y == KB_BOT)) begin
      v = KB_BOT;
    end else begin
      v = KB_ONE;
    end
    return v;
  endfunction

  // Three-valued OR.
  function automatic kb_t tab_or(input kb_t x, input kb_t y);
    kb_t v;
    if (kb_known(x) && kb_known(y)) begin
      v = ((x == KB_ONE) || (y == KB_ONE)) ? KB_ONE : KB_ZERO;
    end else if ((x == KB_TOP) || (y == KB_TOP)) begin
      v = KB_TOP;
    end else begin
      v = ((x == KB_ONE) || (y == KB_ONE)) ? KB_ONE : KB_BOT;
    end
    return v;
  endfunction

  // Three-valued XOR.
  function automatic kb_t tab_xor(input kb_t x, input kb_t y);
    kb_t v;
    if (kb_known(x) && kb_known(y)) begin
      v = (x != y) ? KB_ONE : KB_ZERO;
    end else if ((x == KB_TOP) || (y == KB_TOP)) begin
      v = KB_TOP;
    end else begin
      v = ((x == KB_ONE) || (y == KB_ONE)) ? KB_ONE : KB_BOT;
    end
    return v;
  endfunction

endpackage

// ----- hdl/known_bits_abstract_alu.sv -----
// ----------------------------------------------------------------------------
// known_bits_abstract_alu: known-bits abstract ALU top level
// Registers each input word, evaluates the selected abstract operation in
// one pass and holds the result in an output register.
// ----------------------------------------------------------------------------
// Each word passes the input register and then the result register.
// Throughput: one word per cycle while out_ready is high; the input register
// and result register form a two-stage pipeline, so a held result stalls the
// input stage once that stage is full.
// Reset: synchronous active-low rst_n clears both stage valid flags; the
// payload registers are not reset.
module known_bits_abstract_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  kbalu_pkg::kbalu_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output kbalu_pkg::kbalu_out_t  out_data
);
  import kbalu_pkg::*;

  logic             s1_v_r;
  kbalu_in_t        s1_r;
  logic             out_v_r;
  kbalu_out_t       out_r;
  kbalu_out_t       out_nxt;
  logic             s1_adv;
  logic [WIDTH-1:0] a_z;
  logic [WIDTH-1:0] a_o;
  logic [WIDTH-1:0] b_z;
  logic [WIDTH-1:0] b_o;
  logic [WIDTH-1:0] bw_z;
  logic [WIDTH-1:0] bw_o;
  logic [WIDTH-1:0] sh_z;
  logic [WIDTH-1:0] sh_o;
  kb_t              cmp_res;

  // Pipeline handshake: the input stage moves on when the result register
  // is empty or being drained.
  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_adv;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_v_r <= in_valid;
      end
      if (s1_adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
    if (s1_adv && s1_v_r) begin
      out_r <= out_nxt;
    end
  end

  // Only the low WIDTH bits of each mask take part.
  assign a_z = s1_r.a_can_zero[WIDTH-1:0];
  assign a_o = s1_r.a_can_one[WIDTH-1:0];
  assign b_z = s1_r.b_can_zero[WIDTH-1:0];
  assign b_o = s1_r.b_can_one[WIDTH-1:0];

  kbalu_bitwise #(.WIDTH(WIDTH)) u_bitwise (
    .op    (s1_r.op),
    .a_z   (a_z),
    .a_o   (a_o),
    .b_z   (b_z),
    .b_o   (b_o),
    .res_z (bw_z),
    .res_o (bw_o)
  );

  kbalu_shift #(.WIDTH(WIDTH)) u_shift (
    .op    (s1_r.op),
    .a_z   (a_z),
    .a_o   (a_o),
    .b_z   (b_z),
    .b_o   (b_o),
    .res_z (sh_z),
    .res_o (sh_o)
  );

  kbalu_icmp #(.WIDTH(WIDTH)) u_icmp (
    .predicate (s1_r.predicate),
    .a_z       (a_z),
    .a_o       (a_o),
    .b_z       (b_z),
    .b_o       (b_o),
    .res       (cmp_res)
  );

  // Result selection by operation; unused codes give bottom.
  always_comb begin
    out_nxt = '0;
    case (s1_r.op) inside
      OP_AND, OP_OR, OP_XOR: begin
        out_nxt.res_can_zero = DATA_W'(bw_z);
        out_nxt.res_can_one  = DATA_W'(bw_o);
      end
      OP_SHL, OP_LSHR, OP_ASHR: begin
        out_nxt.res_can_zero = DATA_W'(sh_z);
        out_nxt.res_can_one  = DATA_W'(sh_o);
      end
      OP_ICMP: begin
        out_nxt.res_can_zero = DATA_W'(cmp_res[0]);
        out_nxt.res_can_one  = DATA_W'(cmp_res[1]);
      end
      default: out_nxt = '0;
    endcase
  end

endmodule

// ----- hdl/kbalu_bitwise.sv -----
// ----------------------------------------------------------------------------
// kbalu_bitwise: per-bit abstract AND, OR and XOR
// Applies the three-valued table selected by the operation code to every
// bit position independently.
// ----------------------------------------------------------------------------
module kbalu_bitwise #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [2:0]       op,
  input  logic [WIDTH-1:0] a_z,
  input  logic [WIDTH-1:0] a_o,
  input  logic [WIDTH-1:0] b_z,
  input  logic [WIDTH-1:0] b_o,
  output logic [WIDTH-1:0] res_z,
  output logic [WIDTH-1:0] res_o
);
  import kbalu_pkg::*;

  // Each bit position is evaluated on its own.
  always_comb begin
    kb_t x;
    kb_t y;
    kb_t v;
    res_z = '0;
    res_o = '0;
    for (int p = 0; p < WIDTH; p++) begin
      x = kb_pack(a_z[p], a_o[p]);
      y = kb_pack(b_z[p], b_o[p]);
      case (op)
        OP_AND:  v = tab_and(x, y);
        OP_OR:   v = tab_or(x, y);
        OP_XOR:  v = tab_xor(x, y);
        default: v = KB_BOT;
      endcase
      res_z[p] = v[0];
      res_o[p] = v[1];
    end
  end

endmodule

// ----- hdl/kbalu_shift.sv -----
// ----------------------------------------------------------------------------
// kbalu_shift: abstract shifts over a shift-amount window
// Takes the smallest and largest shift that B allows and gathers, for every
// result position, all A bits and the fill value that some shift in the
// window could place there. Right shifts are worked in bit-reversed form.
// ----------------------------------------------------------------------------
module kbalu_shift #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [2:0]       op,
  input  logic [WIDTH-1:0] a_z,
  input  logic [WIDTH-1:0] a_o,
  input  logic [WIDTH-1:0] b_z,
  input  logic [WIDTH-1:0] b_o,
  output logic [WIDTH-1:0] res_z,
  output logic [WIDTH-1:0] res_o
);
  import kbalu_pkg::*;

  localparam int unsigned CW = WIDTH + 1;

  logic             all_top;
  logic             all_bot;
  logic             too_far;
  logic             right;
  logic [WIDTH-1:0] lo;
  logic [WIDTH-1:0] hi;
  logic [WIDTH-1:0] diff;
  logic [WIDTH-1:0] diff_c;
  logic [CW-1:0]    span;
  logic [WIDTH-1:0] win;
  logic [WIDTH-1:0] fill_k;
  kb_t              fill;
  logic [WIDTH-1:0] sa_z;
  logic [WIDTH-1:0] sa_o;
  logic [WIDTH-1:0] cz;
  logic [WIDTH-1:0] co;

  // Whole-operand special cases and the shift window bounds.
  assign right   = (op != OP_SHL);
  assign all_top = (&(a_z & a_o)) || (&(b_z & b_o));
  assign all_bot = !(|(a_z | a_o)) || !(&(b_z | b_o));
  assign lo      = b_o & ~b_z;
  assign hi      = b_o;
  assign too_far = ({1'b0, lo} >= CW'(WIDTH));
  assign diff    = hi - lo;
  assign diff_c  = ({1'b0, diff} > CW'(WIDTH)) ? WIDTH'(WIDTH) : diff;
  assign span    = {1'b0, lo} + {1'b0, diff_c};
  assign fill    = (op == OP_ASHR) ? kb_pack(a_z[WIDTH-1], a_o[WIDTH-1]) : KB_ZERO;

  // Distance window and fill reach, plus A in left-shift orientation.
  always_comb begin
    for (int d = 0; d < WIDTH; d++) begin
      win[d]    = (CW'(d) >= {1'b0, lo}) && (CW'(d) <= span);
      fill_k[d] = (CW'(d) < span);
      sa_z[d]   = right ? a_z[WIDTH-1-d] : a_z[d];
      sa_o[d]   = right ? a_o[WIDTH-1-d] : a_o[d];
    end
  end

  // Gather the classes of everything that can land on each position.
  always_comb begin
    logic sb;
    logic st;
    logic sz;
    logic so;
    cz = '0;
    co = '0;
    for (int k = 0; k < WIDTH; k++) begin
      sb = fill_k[k] && (fill == KB_BOT);
      st = fill_k[k] && (fill == KB_TOP);
      sz = fill_k[k] && (fill == KB_ZERO);
      so = fill_k[k] && (fill == KB_ONE);
      for (int j = 0; j <= k; j++) begin
        if (win[k-j]) begin
          sb = sb | (~sa_z[j] & ~sa_o[j]);
          st = st | ( sa_z[j] &  sa_o[j]);
          sz = sz | ( sa_z[j] & ~sa_o[j]);
          so = so | (~sa_z[j] &  sa_o[j]);
        end
      end
      if (sb) begin
        cz[k] = 1'b0;
        co[k] = 1'b0;
      end else if (st || (sz && so)) begin
        cz[k] = 1'b1;
        co[k] = 1'b1;
      end else if (so) begin
        cz[k] = 1'b0;
        co[k] = 1'b1;
      end else begin
        cz[k] = 1'b1;
        co[k] = 1'b0;
      end
    end
  end

  // Final selection, restoring bit order for right shifts.
  always_comb begin
    if (all_top) begin
      res_z = '1;
      res_o = '1;
    end else if (all_bot) begin
      res_z = '0;
      res_o = '0;
    end else if (too_far) begin
      res_z = '1;
      res_o = '0;
    end else begin
      for (int i = 0; i < WIDTH; i++) begin
        res_z[i] = right ? cz[WIDTH-1-i] : cz[i];
        res_o[i] = right ? co[WIDTH-1-i] : co[i];
      end
    end
  end

endmodule

// ----- hdl/kbalu_icmp.sv -----
// ----------------------------------------------------------------------------
// kbalu_icmp: abstract integer compare
// Finds the most significant position that decides or blurs the ordering,
// and separately checks equality over all bits, then maps the outcome onto
// the selected predicate as a one-bit abstract truth value.
// ----------------------------------------------------------------------------
module kbalu_icmp #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [3:0]       predicate,
  input  logic [WIDTH-1:0] a_z,
  input  logic [WIDTH-1:0] a_o,
  input  logic [WIDTH-1:0] b_z,
  input  logic [WIDTH-1:0] b_o,
  output kbalu_pkg::kb_t   res
);
  import kbalu_pkg::*;

  // Ordering facts that one position can establish.
  typedef enum logic [2:0] {
    CMP_LT  = 3'd0,
    CMP_EQ  = 3'd1,
    CMP_GT  = 3'd2,
    CMP_UNK = 3'd3,
    CMP_NLT = 3'd4,
    CMP_NGT = 3'd5
  } cmp_t;

  logic             sgn;
  logic [WIDTH-1:0] unk;
  logic [WIDTH-1:0] differ;
  logic [WIDTH-1:0] stop;
  logic [WIDTH-1:0] first;
  cmp_t             code [WIDTH];
  cmp_t             order;

  assign sgn = (predicate == PRED_SGT) || (predicate == PRED_SGE) ||
               (predicate == PRED_SLT) || (predicate == PRED_SLE);

  // Per-position classification and the fact each position would give.
  always_comb begin
    kb_t  x;
    kb_t  y;
    logic rev;
    for (int p = 0; p < WIDTH; p++) begin
      x         = kb_pack(a_z[p], a_o[p]);
      y         = kb_pack(b_z[p], b_o[p]);
      rev       = sgn && (p == WIDTH - 1);
      unk[p]    = !kb_known(x) || !kb_known(y);
      differ[p] = kb_known(x) && kb_known(y) && (x != y);
      stop[p]   = unk[p] || differ[p];
      if (!kb_known(x) && !kb_known(y)) begin
        code[p] = CMP_UNK;
      end else if (!kb_known(y)) begin
        code[p] = ((x == KB_ONE) != rev) ? CMP_NLT : CMP_NGT;
      end else if (!kb_known(x)) begin
        code[p] = ((y == KB_ONE) != rev) ? CMP_NGT : CMP_NLT;
      end else begin
        code[p] = ((x == KB_ZERO) != rev) ? CMP_LT : CMP_GT;
      end
    end
  end

  // The most significant stopping position decides the ordering.
  always_comb begin
    logic [2:0] acc;
    acc = '0;
    for (int p = 0; p < WIDTH; p++) begin
      first[p] = stop[p] && !(|(stop >> (p + 1)));
      acc      = acc | (first[p] ? 3'(code[p]) : 3'b000);
    end
    order = (|stop) ? cmp_t'(acc) : CMP_EQ;
  end

  // Predicate mapping.
  always_comb begin
    if ((&(a_z & a_o)) || (&(b_z & b_o))) begin
      res = KB_TOP;
    end else if (!(|(a_z | a_o)) || !(|(b_z | b_o))) begin
      res = KB_BOT;
    end else begin
      case (predicate) inside
        PRED_EQ: begin
          if (|differ)   res = KB_ZERO;
          else if (|unk) res = KB_TOP;
          else           res = KB_ONE;
        end
        PRED_NE: begin
          if (|differ)   res = KB_ONE;
          else if (|unk) res = KB_TOP;
          else           res = KB_ZERO;
        end
        PRED_UGT, PRED_SGT: begin
          if (order == CMP_GT)                         res = KB_ONE;
          else if (order == CMP_NLT || order == CMP_UNK) res = KB_TOP;
          else                                         res = KB_ZERO;
        end
        PRED_UGE, PRED_SGE: begin
          if (order == CMP_EQ || order == CMP_NLT || order == CMP_GT) res = KB_ONE;
          else if (order == CMP_LT)                                  res = KB_ZERO;
          else                                                       res = KB_TOP;
        end
        PRED_ULT, PRED_SLT: begin
          if (order == CMP_LT)                         res = KB_ONE;
          else if (order == CMP_NGT || order == CMP_UNK) res = KB_TOP;
          else                                         res = KB_ZERO;
        end
        PRED_ULE, PRED_SLE: begin
          if (order == CMP_EQ || order == CMP_NGT || order == CMP_LT) res = KB_ONE;
          else if (order == CMP_GT)                                  res = KB_ZERO;
          else                                                       res = KB_TOP;
        end
        default: res = KB_BOT;
      endcase
    end
  end

endmodule
